/* hw/rtl/thbt_pkg.sv */
// Shared types and codes for the tagged hash bucket table.
package thbt_pkg;

  localparam int PAY_W = 62;

  typedef logic [1:0]       tag_t;
  typedef logic [PAY_W-1:0] pay_t;
  typedef logic [2:0]       action_t;
  typedef logic [1:0]       status_t;

  // Word tags.
  localparam tag_t TAG_NIL  = 2'd0;
  localparam tag_t TAG_SET  = 2'd1;
  localparam tag_t TAG_MOVE = 2'd2;
  localparam tag_t TAG_TOMB = 2'd3;

  // Operations.
  localparam action_t ACT_GET     = 3'd0;
  localparam action_t ACT_PUT     = 3'd1;
  localparam action_t ACT_XCHG    = 3'd2;
  localparam action_t ACT_DELETE  = 3'd3;
  localparam action_t ACT_LOCK    = 3'd4;
  localparam action_t ACT_MOVE_IN = 3'd5;

  // Result codes.
  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_SKIP   = 2'd1;
  localparam status_t ST_RESIZE = 2'd2;
  localparam status_t ST_STOP   = 2'd3;

  typedef struct packed {
    tag_t tag;
    pay_t pay;
  } word_t;

  typedef struct packed {
    word_t key_word;
    word_t value_word;
  } bucket_t;

  typedef struct packed {
    status_t status;
    pay_t    old_value;
    logic    moved;
  } rsp_t;

endpackage

/* hw/rtl/thbt_update.sv */
// Read-modify-write rules applied to one bucket for one operation.
module thbt_update (
  input  thbt_pkg::action_t action,
  input  thbt_pkg::pay_t    key,
  input  thbt_pkg::pay_t    value,
  input  thbt_pkg::pay_t    expected,
  input  logic              in_range,
  input  thbt_pkg::bucket_t cur,
  output thbt_pkg::bucket_t nxt,
  output thbt_pkg::rsp_t    rsp
);
  import thbt_pkg::*;

  tag_t kt;
  tag_t vt;
  pay_t kpay;
  pay_t vpay;
  tag_t lk;
  tag_t lv;

  assign kt   = cur.key_word.tag;
  assign vt   = cur.value_word.tag;
  assign kpay = cur.key_word.pay;
  assign vpay = cur.value_word.pay;

  always_comb begin
    nxt           = cur;
    rsp.status    = ST_SKIP;
    rsp.old_value = '0;
    rsp.moved     = 1'b0;
    lk            = (kt == TAG_NIL) ? TAG_TOMB : TAG_MOVE;
    lv            = (vt == TAG_MOVE) ? TAG_MOVE : ((vt == TAG_NIL) ? TAG_TOMB : lk);
    if (in_range) begin
      case (action)
        ACT_GET: begin
          if (kt == TAG_MOVE) rsp.status = ST_RESIZE;
          else if (kt != TAG_SET || kpay != key) rsp.status = ST_SKIP;
          else if (vt == TAG_MOVE) rsp.status = ST_RESIZE;
          else if (vt != TAG_SET) rsp.status = ST_SKIP;
          else begin
            rsp.status    = ST_OK;
            rsp.old_value = vpay;
          end
        end
        ACT_PUT: begin
          if (kt == TAG_TOMB) rsp.status = ST_SKIP;
          else if (kt == TAG_MOVE) rsp.status = ST_RESIZE;
          else if (kt == TAG_SET && kpay != key) rsp.status = ST_SKIP;
          else begin
            // A key claimed here stays claimed whatever the value word says.
            if (kt == TAG_NIL) nxt.key_word = '{tag: TAG_SET, pay: key};
            if (vt == TAG_TOMB) rsp.status = ST_SKIP;
            else if (vt == TAG_MOVE) rsp.status = ST_RESIZE;
            else if (vt == TAG_SET) begin
              rsp.status    = ST_STOP;
              rsp.old_value = vpay;
            end else begin
              nxt.value_word = '{tag: TAG_SET, pay: value};
              rsp.status     = ST_OK;
            end
          end
        end
        ACT_XCHG, ACT_DELETE: begin
          if (kt == TAG_MOVE) rsp.status = ST_RESIZE;
          else if (kt != TAG_SET || kpay != key) rsp.status = ST_SKIP;
          else if (vt == TAG_MOVE) rsp.status = ST_RESIZE;
          else if (vt != TAG_SET) rsp.status = ST_SKIP;
          else begin
            rsp.old_value = vpay;
            if (expected != '0 && vpay != expected) rsp.status = ST_STOP;
            else begin
              rsp.status = ST_OK;
              if (action == ACT_XCHG) begin
                nxt.value_word = '{tag: TAG_SET, pay: value};
              end else begin
                nxt.value_word.tag = TAG_TOMB;
                nxt.key_word.tag   = TAG_TOMB;
              end
            end
          end
        end
        ACT_LOCK: begin
          rsp.status = ST_OK;
          if (kt != TAG_TOMB) begin
            nxt.key_word.tag = lk;
            if (vt != TAG_TOMB) begin
              nxt.value_word.tag = lv;
              // A key frozen over an empty value is dead, not moving.
              if (lk == TAG_MOVE && lv == TAG_TOMB) nxt.key_word.tag = TAG_TOMB;
              else rsp.moved = (lk == TAG_MOVE) && (lv == TAG_MOVE);
            end
          end
        end
        ACT_MOVE_IN: begin
          if (kt == TAG_MOVE) rsp.status = ST_RESIZE;
          else if (kt == TAG_SET && kpay != key) rsp.status = ST_SKIP;
          else if (kt == TAG_TOMB) begin
            if (kpay != key) rsp.status = ST_SKIP;
            else rsp.status = (vpay != '0) ? ST_OK : ST_RESIZE;
          end else begin
            if (kt == TAG_NIL) nxt.key_word = '{tag: TAG_SET, pay: key};
            if (vt == TAG_SET) rsp.status = ST_OK;
            else if (vt == TAG_MOVE) rsp.status = ST_RESIZE;
            else if (vt == TAG_NIL) begin
              nxt.value_word = '{tag: TAG_SET, pay: value};
              rsp.status     = ST_OK;
            end else rsp.status = (vpay != '0) ? ST_OK : ST_RESIZE;
          end
        end
        default: begin
          rsp.status = ST_SKIP;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/tagged_hash_bucket_table.sv */
// Top level of the tagged hash bucket table: bucket memory, forwarding and handshakes.
//
// The table holds TABLE_DEPTH buckets, each a tagged key word and a tagged value
// word, in one synchronous memory. Every request beat is one atomic
// read-modify-write of the addressed bucket: the memory is read at the accept
// edge, the operation is applied in the following cycle and the bucket is written
// back as the result moves into the response register, so one request can be
// taken every cycle while responses are taken and no clearing pass runs. When a
// request addresses the bucket being written back in that same cycle, the updated
// bucket is forwarded to it instead of the stale memory read. A response beat may
// wait on rsp_ready while one further request is taken and held. After reset a
// clearing pass writes every bucket to nil, one per cycle; req_ready stays low
// until it is done. A bucket_index at or beyond TABLE_DEPTH leaves the table alone
// and answers skip.
module tagged_hash_bucket_table #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  thbt_pkg::action_t   action,
  input  logic [9:0]          bucket_index,
  input  thbt_pkg::pay_t      key,
  input  thbt_pkg::pay_t      value,
  input  thbt_pkg::pay_t      expected,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output thbt_pkg::status_t   status,
  output thbt_pkg::pay_t      old_value,
  output logic                moved
);
  import thbt_pkg::*;

  localparam int          AW        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [16:0] DEPTH_EXT = 17'(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

  // Bucket storage.
  bucket_t mem [TABLE_DEPTH];
  bucket_t rdata;

  // Clearing pass.
  logic          clr_active;
  logic [AW-1:0] clr_addr;

  // Request side.
  logic [16:0]   idx_ext;
  logic [AW-1:0] req_addr;
  logic          req_in_range;
  logic          req_fire;

  // Update stage.
  logic          s1_valid;
  logic          s1_adv;
  action_t       s1_action;
  pay_t          s1_key;
  pay_t          s1_value;
  pay_t          s1_expected;
  logic [AW-1:0] s1_addr;
  logic          s1_in_range;

  // Forwarding of the bucket written back in the accept cycle.
  logic          fwd_hit;
  bucket_t       fwd_bucket;

  bucket_t       cur_bucket;
  bucket_t       upd_bucket;
  rsp_t          upd_rsp;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  bucket_t       mem_wdata;

  assign idx_ext      = {7'd0, bucket_index};
  assign req_addr     = idx_ext[AW-1:0];
  assign req_in_range = idx_ext < DEPTH_EXT;

  assign s1_adv    = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !clr_active && (!s1_valid || s1_adv);
  assign req_fire  = req_valid && req_ready;

  assign cur_bucket = fwd_hit ? fwd_bucket : rdata;

  thbt_update u_update (
    .action   (s1_action),
    .key      (s1_key),
    .value    (s1_value),
    .expected (s1_expected),
    .in_range (s1_in_range),
    .cur      (cur_bucket),
    .nxt      (upd_bucket),
    .rsp      (upd_rsp)
  );

  assign mem_we    = clr_active || (s1_adv && s1_in_range);
  assign mem_waddr = clr_active ? clr_addr : s1_addr;
  assign mem_wdata = clr_active ? '0 : upd_bucket;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (req_fire) begin
      rdata <= mem[req_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == LAST_ADDR) begin
        clr_active <= 1'b0;
      end
    end
  end

  // Request register and forwarding capture.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      if (req_fire) begin
        s1_valid <= 1'b1;
        fwd_hit  <= s1_adv && s1_in_range && (s1_addr == req_addr);
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      s1_action   <= action;
      s1_key      <= key;
      s1_value    <= value;
      s1_expected <= expected;
      s1_addr     <= req_addr;
      s1_in_range <= req_in_range;
      fwd_bucket  <= upd_bucket;
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      status    <= upd_rsp.status;
      old_value <= upd_rsp.old_value;
      moved     <= upd_rsp.moved;
    end
  end

  // No request may enter while the clearing pass owns the memory.
  a_no_req_in_clear: assert property (@(posedge clk) disable iff (rst)
    clr_active |-> !req_ready && !s1_valid)
    else $error("request taken during clearing pass");

  // The clearing pass ends right after the last bucket is written.
  a_clear_ends: assert property (@(posedge clk) disable iff (rst)
    clr_active && clr_addr == LAST_ADDR |=> !clr_active)
    else $error("clearing pass did not end");

  // A forwarded bucket only serves a request that is in the update stage.
  a_fwd_live: assert property (@(posedge clk) disable iff (rst)
    $past(req_fire) && fwd_hit |-> s1_valid)
    else $error("forwarded bucket without a pending request");

  // Moved is reported only by a successful lock.
  a_moved_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && moved |-> status == ST_OK)
    else $error("moved flag with a failing status");

endmodule
